[rtl/teu_pkg.sv]
// shared constants and types for the trap entry unit
package teu_pkg;

    // status word bit positions
    localparam int unsigned ID_BIT  = 12;
    localparam int unsigned EP_BIT  = 14;
    localparam int unsigned NP_BIT  = 15;
    localparam int unsigned IA_LSB  = 16;
    localparam int unsigned IA_MSB  = 19;

    // vector and cause bases
    localparam logic [31:0] INT_VECTOR_BASE = 32'hFFFF_FE00;
    localparam logic [31:0] INT_CAUSE_BASE  = 32'h0000_FE00;
    localparam logic [31:0] EXC_VECTOR_BASE = 32'hFFFF_FF00;
    localparam logic [31:0] FATAL_VECTOR    = 32'hFFFF_FFD0;
    localparam logic [3:0]  LEVEL_MAX       = 4'hF;

    // halt skip distance on interrupt entry
    localparam logic [31:0] HALT_SKIP = 32'd2;

    // request kinds carried on the input tuser
    localparam logic REQ_INTERRUPT = 1'b0;
    localparam logic REQ_EXCEPTION = 1'b1;

    // save pair selection
    typedef enum logic [1:0] {
        SAVE_NONE   = 2'd0,
        SAVE_NORMAL = 2'd1,
        SAVE_FATAL  = 2'd2
    } save_target_t;

    // stream payload widths (packed, padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned OUT_DATA_W = 200;

    // one request as carried through the input register
    typedef struct packed {
        logic        halt_at_pc;
        logic [31:0] condition_flags;
        logic [31:0] status_word;
        logic [31:0] current_pc;
        logic [15:0] exception_code;
        logic [3:0]  cause_number;
    } request_t;

    // one entry decision
    typedef struct packed {
        save_target_t save_target;
        logic [31:0]  saved_flags;
        logic [31:0]  saved_status_word;
        logic [31:0]  saved_pc;
        logic [31:0]  cause_register;
        logic [31:0]  new_status_word;
        logic [31:0]  next_pc;
        logic         accepted;
    } result_t;

endpackage

[rtl/trap_entry_unit.sv]
// trap entry unit: interrupt and exception acceptance and vector/status assembly
// path: each input transaction is held in the input register, then in the result register
// throughput: one request per cycle unless m_tready stalls; the entry decision is a single pass of
// priority checks and field assembly between the two registers
// reset: asynchronous active-low reset empties both registers; no other state
module trap_entry_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cause_number[3:0], exception_code[19:4], current_pc[51:20],
    // status_word[83:52], condition_flags[115:84], halt_at_pc[116], zero pad
    input  logic [teu_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted[0], next_pc[32:1], new_status_word[64:33], cause_register[96:65],
    // saved_pc[128:97], saved_status_word[160:129], saved_flags[192:161],
    // save_target[194:193], zero pad
    output logic [teu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import teu_pkg::*;

    localparam int unsigned REQ_W = $bits(request_t);
    localparam int unsigned RES_W = $bits(result_t);

    logic     in_valid_reg;
    logic     in_valid_next;
    request_t in_req_reg;
    logic     in_kind_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_res_reg;
    result_t  res;
    logic     out_load;
    logic     in_load;

    logic [3:0] n;
    logic [3:0] ia;
    logic [3:0] lvl;
    logic       int_ok;
    logic [31:0] psw;

    // pipeline handshake
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_req_reg  <= request_t'(s_tdata[REQ_W-1:0]);
            in_kind_reg <= s_tuser;
        end
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    // field decode
    assign n   = in_req_reg.cause_number;
    assign psw = in_req_reg.status_word;
    assign ia  = psw[IA_MSB:IA_LSB];
    assign lvl = (n == LEVEL_MAX) ? LEVEL_MAX : n + 4'd1;
    assign int_ok = !psw[NP_BIT] && !psw[EP_BIT] && !psw[ID_BIT] && (n >= ia);

    // entry decision and field assembly
    always_comb
    begin
        res = '0;
        res.save_target = SAVE_NONE;
        if (in_kind_reg == REQ_INTERRUPT)
        begin
            if (int_ok)
            begin
                res.accepted        = 1'b1;
                res.next_pc         = INT_VECTOR_BASE | {24'd0, n, 4'd0};
                res.new_status_word = psw;
                res.new_status_word[EP_BIT] = 1'b1;
                res.new_status_word[ID_BIT] = 1'b1;
                res.new_status_word[IA_MSB:IA_LSB] = lvl;
                res.cause_register  = INT_CAUSE_BASE | {24'd0, n, 4'd0};
                res.saved_pc        = in_req_reg.halt_at_pc
                                      ? in_req_reg.current_pc + HALT_SKIP
                                      : in_req_reg.current_pc;
                res.saved_status_word = psw;
                res.saved_flags     = in_req_reg.condition_flags;
                res.save_target     = SAVE_NORMAL;
            end
        end
        else if (ia == 4'd0)
        begin
            res.accepted          = 1'b1;
            res.saved_pc          = in_req_reg.current_pc;
            res.saved_status_word = psw;
            res.new_status_word   = psw;
            res.new_status_word[ID_BIT] = 1'b1;
            if (psw[EP_BIT])
            begin
                // double exception goes to the fatal pair
                res.next_pc         = FATAL_VECTOR;
                res.new_status_word[NP_BIT] = 1'b1;
                res.cause_register  = {in_req_reg.exception_code, 16'd0};
                res.save_target     = SAVE_FATAL;
            end
            else
            begin
                res.next_pc         = EXC_VECTOR_BASE | {24'd0, n, 4'd0};
                res.new_status_word[EP_BIT] = 1'b1;
                res.cause_register  = {16'd0, in_req_reg.exception_code};
                res.saved_flags     = in_req_reg.condition_flags;
                res.save_target     = SAVE_NORMAL;
            end
        end
    end

    // output port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_res_reg};

    // checks
    a_accept_matches_target: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_res_reg.accepted == (out_res_reg.save_target != SAVE_NONE)))
        else $error("accepted flag disagrees with save target");

    a_fatal_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.save_target == SAVE_FATAL)
        |-> (out_res_reg.next_pc == FATAL_VECTOR && out_res_reg.saved_flags == '0))
        else $error("fatal entry with wrong vector or flags");

    a_entry_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.accepted) |-> out_res_reg.new_status_word[ID_BIT])
        else $error("accepted entry left interrupts enabled");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_load) |=> in_valid_reg)
        else $error("input stage dropped a stalled transaction");

endmodule
